// ===== design/swsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter package
// Types, character codes and small helper functions shared by the splitter.
// ----------------------------------------------------------------------------
package swsp_pkg;

  // Most result items one input byte can produce, and result buffer depth
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned RBUF_DEPTH  = 4;

  // Configuration port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_MAX_WORDS = 1'b0;   // register index (paddr[2])
  localparam logic [7:0]  MAX_WORDS_RESET = 8'd64;
  localparam logic [7:0]  WORD_COUNT_MAX  = 8'd255;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_SQUOTE  = 3'd2,
    MODE_DQUOTE  = 3'd3,
    MODE_DQ_ESC  = 3'd4,
    MODE_ESC     = 3'd5,
    MODE_TILDE   = 3'd6,
    MODE_DRAIN   = 3'd7
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        word_quoted;
    logic [15:0] consumed;
    logic        last;
  } result_t;

  // Results of one input byte, packed from index 0
  typedef struct packed {
    logic [1:0]                count;
    result_t [MAX_RES-1:0]     res;
  } push_t;

  // Scanner state, apart from the byte position
  typedef struct packed {
    mode_e      mode;
    logic       in_word;
    logic       word_empty;
    logic       word_has_quote;
    logic [7:0] word_count;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:           MODE_BETWEEN,
    in_word:        1'b0,
    word_empty:     1'b1,
    word_has_quote: 1'b0,
    word_count:     8'd0
  };

  function automatic logic is_gap(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_meta(logic [7:0] b);
    logic hit;
    case (b) inside
      CH_SEMI, CH_PIPE, CH_AMP, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN, CH_BTICK,
      CH_DOLLAR, CH_LF, CH_STAR, CH_QMARK, CH_LBRACK, CH_LBRACE, CH_RBRACE:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // State effect of closing the current word
  function automatic scan_state_t end_word(scan_state_t s);
    scan_state_t r;
    r = s;
    if (s.word_count != WORD_COUNT_MAX) begin
      r.word_count = s.word_count + 8'd1;
    end
    r.in_word = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/swsp_in_if.sv =====
// ----------------------------------------------------------------------------
// Splitter input channel
// Valid/ready channel carrying one command-line byte per transfer.
// ----------------------------------------------------------------------------
interface swsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/swsp_out_if.sv =====
// ----------------------------------------------------------------------------
// Splitter result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface swsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        word_quoted;
  logic [15:0] consumed;
  logic        last;

  modport source (output valid, output kind, output out_byte, output word_quoted,
                  output consumed, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input word_quoted,
                  input consumed, input last, output ready);
endinterface

// ===== design/shell_word_splitter.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter
// Splits a command line into words with quoting and escapes, one byte per
// cycle while the buffer has room, and reports where and why splitting stopped.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Payload
//  byte_i    in   valid/ready        in_byte
//  res_o     out  valid/ready        kind, out_byte, word_quoted, consumed, last
//  APB       in   psel/penable       max_words at address 0
//
//  One byte is taken per cycle while the buffer has room; a byte goes from
//  the input register through the step logic into the result buffer, and its
//  results leave from the buffer head in order. A byte with k results makes
//  k result transfers; the input stalls when the buffer lacks room for three.
//  Reset clears the scanner, the buffer and sets max_words to 64.
// ----------------------------------------------------------------------------
module shell_word_splitter #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  swsp_in_if.sink                           byte_i,
  swsp_out_if.source                        res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swsp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [swsp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swsp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic                     bval_q;
  logic [7:0]               byte_q;
  logic                     advance;
  logic                     room;
  logic                     pop;
  logic [7:0]               max_words_q;
  swsp_pkg::scan_state_t    st_q;
  swsp_pkg::scan_state_t    st_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] pos_d;
  swsp_pkg::push_t          push;
  swsp_pkg::push_t          push_gated;
  swsp_pkg::result_t        head;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[swsp_pkg::APB_ADDR_W-1] == swsp_pkg::REG_MAX_WORDS) ?
                  {{(swsp_pkg::APB_DATA_W-8){1'b0}}, max_words_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q <= swsp_pkg::MAX_WORDS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[swsp_pkg::APB_ADDR_W-1] == swsp_pkg::REG_MAX_WORDS) begin
      max_words_q <= pwdata[7:0];
    end
  end

  // Input register
  assign advance      = bval_q && room;
  assign byte_i.ready = !bval_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bval_q <= 1'b0;
    end else if (byte_i.ready) begin
      bval_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.in_byte;
    end
  end

  // Scanner step
  swsp_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .st_i        (st_q),
    .pos_i       (pos_q),
    .in_byte_i   (byte_q),
    .max_words_i (max_words_q),
    .st_o        (st_d),
    .pos_o       (pos_d),
    .push_o      (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= swsp_pkg::SCAN_RESET;
      pos_q <= '0;
    end else if (advance) begin
      st_q  <= st_d;
      pos_q <= pos_d;
    end
  end

  // Result buffer and output
  always_comb begin
    push_gated = push;
    if (!advance) begin
      push_gated.count = 2'd0;
    end
  end

  assign pop = res_o.valid && res_o.ready;

  swsp_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_gated),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (res_o.valid),
    .head_o  (head)
  );

  assign res_o.kind        = head.kind;
  assign res_o.out_byte    = head.out_byte;
  assign res_o.word_quoted = head.word_quoted;
  assign res_o.consumed    = head.consumed;
  assign res_o.last        = head.last;

  // A terminator always leaves the scanner in its reset state
  a_nul_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && byte_q == swsp_pkg::CH_NUL |=>
      st_q == swsp_pkg::SCAN_RESET && pos_q == '0)
    else $error("terminator did not restart the line");

  // A finish is always the last result of its byte
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == swsp_pkg::KIND_OK || res_o.kind == swsp_pkg::KIND_ERR)
      |-> res_o.last)
    else $error("finish result not marked last");

  // Bytes after a finish produce nothing
  a_drain_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && st_q.mode == swsp_pkg::MODE_DRAIN |-> push.count == 2'd0)
    else $error("result produced while draining");

endmodule

// ===== design/swsp_step.sv =====
// ----------------------------------------------------------------------------
// Splitter step logic
// Combinational update of the scanner for one byte: next state and up to
// three result items, in order.
// ----------------------------------------------------------------------------
module swsp_step #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  swsp_pkg::scan_state_t     st_i,
  input  logic [POSITION_BITS-1:0]  pos_i,
  input  logic [7:0]                in_byte_i,
  input  logic [7:0]                max_words_i,
  output swsp_pkg::scan_state_t     st_o,
  output logic [POSITION_BITS-1:0]  pos_o,
  output swsp_pkg::push_t           push_o
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  swsp_pkg::scan_state_t    nxt_st;
  logic [POSITION_BITS-1:0] nxt_pos;
  logic                     restart;
  logic                     do_hdl;
  logic                     do_part;
  logic                     pre_en;
  logic [7:0]               pre_byte;
  logic                     emit_en;
  logic [7:0]               emit_byte;
  logic                     end_en;
  logic                     end_q;
  logic                     fin_en;
  logic                     fin_ok;
  logic [7:0]               fin_stop;
  logic [15:0]              fin_cons;

  swsp_pkg::result_t                     cand [4];
  logic [3:0]                            cand_v;
  swsp_pkg::result_t [swsp_pkg::MAX_RES-1:0] res;
  logic [1:0]                            n;

  // Next state and result flags; the order of updates follows the scan rules
  always_comb begin
    nxt_st    = st_i;
    nxt_pos   = pos_i;
    restart   = 1'b0;
    do_hdl    = 1'b0;
    do_part   = 1'b0;
    pre_en    = 1'b0;
    pre_byte  = swsp_pkg::CH_NUL;
    emit_en   = 1'b0;
    emit_byte = swsp_pkg::CH_NUL;
    end_en    = 1'b0;
    end_q     = 1'b0;
    fin_en    = 1'b0;
    fin_ok    = 1'b0;
    fin_stop  = swsp_pkg::CH_NUL;
    fin_cons  = '0;

    // Modes with their own handling before the common byte handling
    unique case (st_i.mode)
      swsp_pkg::MODE_DRAIN: begin
        if (in_byte_i == swsp_pkg::CH_NUL) begin
          nxt_st  = swsp_pkg::SCAN_RESET;
          nxt_pos = '0;
          restart = 1'b1;
        end
      end
      swsp_pkg::MODE_ESC: begin
        if (in_byte_i == swsp_pkg::CH_NUL) begin
          fin_en = 1'b1;
        end else begin
          emit_en               = 1'b1;
          emit_byte             = in_byte_i;
          nxt_st.word_empty     = 1'b0;
          nxt_st.word_has_quote = 1'b1;
          nxt_st.mode           = swsp_pkg::MODE_WORD;
        end
      end
      swsp_pkg::MODE_DQ_ESC: begin
        nxt_st.mode = swsp_pkg::MODE_DQUOTE;
        case (in_byte_i) inside
          swsp_pkg::CH_BSLASH, swsp_pkg::CH_DQUOTE, swsp_pkg::CH_DOLLAR,
          swsp_pkg::CH_BTICK: begin
            emit_en           = 1'b1;
            emit_byte         = in_byte_i;
            nxt_st.word_empty = 1'b0;
          end
          default: begin
            // backslash stays literal, byte handled as in double quotes
            pre_en            = 1'b1;
            pre_byte          = swsp_pkg::CH_BSLASH;
            nxt_st.word_empty = 1'b0;
            do_hdl            = 1'b1;
          end
        endcase
      end
      swsp_pkg::MODE_TILDE: begin
        if (in_byte_i != swsp_pkg::CH_NUL && in_byte_i != swsp_pkg::CH_SLASH &&
            !swsp_pkg::is_gap(in_byte_i)) begin
          // expanding tilde: stop here
          if (st_i.in_word) begin
            end_en = 1'b1;
            end_q  = st_i.word_has_quote;
            nxt_st = swsp_pkg::end_word(st_i);
          end
          fin_en   = 1'b1;
          fin_ok   = 1'b1;
          fin_stop = swsp_pkg::CH_TILDE;
          fin_cons = 16'(pos_i);
        end else if (!st_i.in_word && st_i.word_count >= max_words_i) begin
          fin_en = 1'b1;
        end else begin
          // literal tilde, then the byte itself inside the word
          if (!st_i.in_word) begin
            nxt_st.in_word        = 1'b1;
            nxt_st.word_has_quote = 1'b0;
          end
          nxt_st.mode       = swsp_pkg::MODE_WORD;
          pre_en            = 1'b1;
          pre_byte          = swsp_pkg::CH_TILDE;
          nxt_st.word_empty = 1'b0;
          if (pos_i != '1) begin
            nxt_pos = pos_i + POS_ONE;
          end
          do_hdl = 1'b1;
        end
      end
      default: do_hdl = 1'b1;
    endcase

    // Common byte handling
    if (do_hdl) begin
      unique case (nxt_st.mode)
        swsp_pkg::MODE_BETWEEN: begin
          if (swsp_pkg::is_gap(in_byte_i)) begin
            nxt_st.mode = swsp_pkg::MODE_BETWEEN;
          end else if (in_byte_i == swsp_pkg::CH_NUL || swsp_pkg::is_meta(in_byte_i)) begin
            fin_en   = 1'b1;
            fin_ok   = 1'b1;
            fin_stop = in_byte_i;
            fin_cons = 16'(nxt_pos);
          end else if (in_byte_i == swsp_pkg::CH_TILDE) begin
            nxt_st.in_word = 1'b0;
            nxt_st.mode    = swsp_pkg::MODE_TILDE;
          end else if (nxt_st.word_count >= max_words_i) begin
            fin_en = 1'b1;
          end else begin
            nxt_st.in_word        = 1'b1;
            nxt_st.word_empty     = 1'b1;
            nxt_st.word_has_quote = 1'b0;
            nxt_st.mode           = swsp_pkg::MODE_WORD;
            do_part               = 1'b1;
          end
        end
        swsp_pkg::MODE_WORD: begin
          if (in_byte_i == swsp_pkg::CH_NUL || swsp_pkg::is_meta(in_byte_i)) begin
            end_en   = 1'b1;
            end_q    = nxt_st.word_has_quote;
            nxt_st   = swsp_pkg::end_word(nxt_st);
            fin_en   = 1'b1;
            fin_ok   = 1'b1;
            fin_stop = in_byte_i;
            fin_cons = 16'(nxt_pos);
          end else if (swsp_pkg::is_gap(in_byte_i)) begin
            end_en      = 1'b1;
            end_q       = nxt_st.word_has_quote;
            nxt_st      = swsp_pkg::end_word(nxt_st);
            nxt_st.mode = swsp_pkg::MODE_BETWEEN;
          end else if (in_byte_i == swsp_pkg::CH_TILDE && nxt_st.word_empty) begin
            nxt_st.mode = swsp_pkg::MODE_TILDE;
          end else begin
            do_part = 1'b1;
          end
        end
        swsp_pkg::MODE_SQUOTE: begin
          if (in_byte_i == swsp_pkg::CH_SQUOTE) begin
            nxt_st.mode = swsp_pkg::MODE_WORD;
          end else if (in_byte_i == swsp_pkg::CH_NUL) begin
            fin_en = 1'b1;
          end else begin
            emit_en           = 1'b1;
            emit_byte         = in_byte_i;
            nxt_st.word_empty = 1'b0;
          end
        end
        swsp_pkg::MODE_DQUOTE: begin
          if (in_byte_i == swsp_pkg::CH_DQUOTE) begin
            nxt_st.mode = swsp_pkg::MODE_WORD;
          end else if (in_byte_i == swsp_pkg::CH_BSLASH) begin
            nxt_st.mode = swsp_pkg::MODE_DQ_ESC;
          end else if (in_byte_i == swsp_pkg::CH_NUL || in_byte_i == swsp_pkg::CH_DOLLAR ||
                       in_byte_i == swsp_pkg::CH_BTICK) begin
            fin_en = 1'b1;
          end else begin
            emit_en           = 1'b1;
            emit_byte         = in_byte_i;
            nxt_st.word_empty = 1'b0;
          end
        end
        default: nxt_st.mode = nxt_st.mode;
      endcase
    end

    // Part of a word outside quotes
    if (do_part) begin
      if (in_byte_i == swsp_pkg::CH_SQUOTE) begin
        nxt_st.word_has_quote = 1'b1;
        nxt_st.mode           = swsp_pkg::MODE_SQUOTE;
      end else if (in_byte_i == swsp_pkg::CH_DQUOTE) begin
        nxt_st.word_has_quote = 1'b1;
        nxt_st.mode           = swsp_pkg::MODE_DQUOTE;
      end else if (in_byte_i == swsp_pkg::CH_BSLASH) begin
        nxt_st.mode = swsp_pkg::MODE_ESC;
      end else begin
        emit_en           = 1'b1;
        emit_byte         = in_byte_i;
        nxt_st.word_empty = 1'b0;
      end
    end

    // Finish: restart the line on the terminator, else drop to its end
    if (fin_en) begin
      if (in_byte_i == swsp_pkg::CH_NUL) begin
        nxt_st  = swsp_pkg::SCAN_RESET;
        nxt_pos = '0;
        restart = 1'b1;
      end else begin
        nxt_st.mode = swsp_pkg::MODE_DRAIN;
      end
    end

    // Position count, held while a tilde waits for the next byte
    if (!restart && nxt_st.mode != swsp_pkg::MODE_TILDE && nxt_pos != '1) begin
      nxt_pos = nxt_pos + POS_ONE;
    end
  end

  assign st_o  = nxt_st;
  assign pos_o = nxt_pos;

  // Pack result items in order: leading byte, word byte, word end, finish
  always_comb begin
    cand[0] = '{kind: swsp_pkg::KIND_BYTE, out_byte: pre_byte, word_quoted: 1'b0,
                consumed: 16'd0, last: 1'b0};
    cand[1] = '{kind: swsp_pkg::KIND_BYTE, out_byte: emit_byte, word_quoted: 1'b0,
                consumed: 16'd0, last: 1'b0};
    cand[2] = '{kind: swsp_pkg::KIND_END, out_byte: swsp_pkg::CH_NUL, word_quoted: end_q,
                consumed: 16'd0, last: 1'b0};
    if (fin_ok) begin
      cand[3] = '{kind: swsp_pkg::KIND_OK, out_byte: fin_stop, word_quoted: 1'b0,
                  consumed: fin_cons, last: 1'b0};
    end else begin
      cand[3] = '{kind: swsp_pkg::KIND_ERR, out_byte: swsp_pkg::CH_NUL, word_quoted: 1'b0,
                  consumed: 16'd0, last: 1'b0};
    end
    cand_v = {fin_en, end_en, emit_en, pre_en};

    res = '0;
    n   = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k] && n != 2'd3) begin
        res[n] = cand[k];
        n      = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    push_o.count = n;
    push_o.res   = res;
  end

endmodule

// ===== design/swsp_rbuf.sv =====
// ----------------------------------------------------------------------------
// Splitter result buffer
// Small register FIFO: takes up to three results in one cycle, gives one.
// ----------------------------------------------------------------------------
module swsp_rbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swsp_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output swsp_pkg::result_t head_o
);

  localparam int unsigned IDX_W = $clog2(swsp_pkg::RBUF_DEPTH);
  localparam int unsigned CNT_W = $clog2(swsp_pkg::RBUF_DEPTH + 1);

  swsp_pkg::result_t mem_q [swsp_pkg::RBUF_DEPTH];
  logic [IDX_W-1:0]  head_q;
  logic [IDX_W-1:0]  tail_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  free;

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[head_q];

  // Room for a full set of results, counting the transfer going out now
  assign free   = CNT_W'(swsp_pkg::RBUF_DEPTH) - count_q + CNT_W'(pop_i);
  assign room_o = (free >= CNT_W'(swsp_pkg::MAX_RES));

  // Storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < swsp_pkg::MAX_RES; k++) begin
      if (2'(k) < push_i.count) begin
        mem_q[tail_q + IDX_W'(k)] <= push_i.res[k];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + IDX_W'(push_i.count);
      head_q  <= head_q + IDX_W'(pop_i);
      count_q <= count_q + CNT_W'(push_i.count) - CNT_W'(pop_i);
    end
  end

  // Fill level never passes the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(swsp_pkg::RBUF_DEPTH))
    else $error("result buffer overflow");

endmodule

// ===== tb/sv/swsp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter scoreboard
// Predicts the result items of every byte transfer into the splitter and
// checks the result transfers against them in order.
// ----------------------------------------------------------------------------
package swsp_tb_pkg;
  import swsp_pkg::*;

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;   // POSITION_BITS = 16

  function automatic bit is_blank(logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  // Unquoted characters that stop the split
  function automatic bit is_stop(logic [7:0] ch);
    case (ch)
      CH_SEMI, CH_PIPE, CH_AMP, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN, CH_BTICK,
      CH_DOLLAR, CH_LF, CH_STAR, CH_QMARK, CH_LBRACK, CH_LBRACE, CH_RBRACE:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  class split_scoreboard;
    // Predictor state
    logic [7:0]  word_limit;
    mode_e       scan;
    bit          open_word;
    bit          part_empty;
    bit          had_quote;
    bit          restarted;
    logic [7:0]  words_seen;
    logic [15:0] position;
    result_t     step_res[$];
    result_t     expected_q[$];

    // Tallies
    int n_bytes;
    int n_results;
    int n_ends;
    int n_ok;
    int n_err;
    int mismatches;

    function new();
      word_limit = MAX_WORDS_RESET;
      clear_line();
    endfunction

    function void set_max_words(logic [7:0] v);
      word_limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_line();
      scan       = MODE_BETWEEN;
      open_word  = 1'b0;
      part_empty = 1'b1;
      had_quote  = 1'b0;
      words_seen = 8'd0;
      position   = 16'd0;
    endfunction

    function void bump();
      if (position != POS_LIMIT) begin
        position++;
      end
    endfunction

    function void push(kind_e k, logic [7:0] ch, bit q, logic [15:0] cons);
      result_t r;
      if (step_res.size() < MAX_RES) begin
        r.kind        = k;
        r.out_byte    = ch;
        r.word_quoted = q;
        r.consumed    = cons;
        r.last        = 1'b0;
        step_res.push_back(r);
      end
    endfunction

    function void emit(logic [7:0] ch);
      push(KIND_BYTE, ch, 1'b0, 16'd0);
      part_empty = 1'b0;
    endfunction

    function void close_word();
      push(KIND_END, CH_NUL, had_quote, 16'd0);
      if (words_seen != WORD_COUNT_MAX) begin
        words_seen++;
      end
      open_word = 1'b0;
    endfunction

    // Ends the split; a finish on a non-zero byte drains to the terminator
    function void finish_line(bit ok, logic [7:0] stop, logic [7:0] ch);
      if (ok) begin
        push(KIND_OK, stop, 1'b0, position);
      end else begin
        push(KIND_ERR, CH_NUL, 1'b0, 16'd0);
      end
      if (ch == CH_NUL) begin
        clear_line();
        restarted = 1'b1;
      end else begin
        scan = MODE_DRAIN;
      end
    endfunction

    function void word_part(logic [7:0] ch);
      if (ch == CH_SQUOTE) begin
        had_quote = 1'b1;
        scan      = MODE_SQUOTE;
      end else if (ch == CH_DQUOTE) begin
        had_quote = 1'b1;
        scan      = MODE_DQUOTE;
      end else if (ch == CH_BSLASH) begin
        scan = MODE_ESC;
      end else begin
        emit(ch);
      end
    endfunction

    function void start_word(logic [7:0] ch);
      if (words_seen >= word_limit) begin
        finish_line(1'b0, CH_NUL, ch);
      end else begin
        open_word  = 1'b1;
        part_empty = 1'b1;
        had_quote  = 1'b0;
        scan       = MODE_WORD;
        word_part(ch);
      end
    endfunction

    // Plain handling of one byte in the current mode
    function void handle(logic [7:0] ch);
      case (scan)
        MODE_BETWEEN: begin
          if (!is_blank(ch)) begin
            if (ch == CH_NUL || is_stop(ch)) begin
              finish_line(1'b1, ch, ch);
            end else if (ch == CH_TILDE) begin
              open_word = 1'b0;
              scan      = MODE_TILDE;
            end else begin
              start_word(ch);
            end
          end
        end
        MODE_WORD: begin
          if (ch == CH_NUL || is_stop(ch)) begin
            close_word();
            finish_line(1'b1, ch, ch);
          end else if (is_blank(ch)) begin
            close_word();
            scan = MODE_BETWEEN;
          end else if (ch == CH_TILDE && part_empty) begin
            scan = MODE_TILDE;
          end else begin
            word_part(ch);
          end
        end
        MODE_SQUOTE: begin
          if (ch == CH_SQUOTE) begin
            scan = MODE_WORD;
          end else if (ch == CH_NUL) begin
            finish_line(1'b0, CH_NUL, ch);
          end else begin
            emit(ch);
          end
        end
        MODE_DQUOTE: begin
          if (ch == CH_DQUOTE) begin
            scan = MODE_WORD;
          end else if (ch == CH_BSLASH) begin
            scan = MODE_DQ_ESC;
          end else if (ch == CH_NUL || ch == CH_DOLLAR || ch == CH_BTICK) begin
            finish_line(1'b0, CH_NUL, ch);
          end else begin
            emit(ch);
          end
        end
        default: ;
      endcase
    endfunction

    // Notes one accepted byte and queues the results it should cause
    function void note_byte(logic [7:0] ch);
      result_t r;
      step_res.delete();
      restarted = 1'b0;
      n_bytes++;
      case (scan)
        MODE_DRAIN: begin
          if (ch == CH_NUL) begin
            clear_line();
            restarted = 1'b1;
          end
        end
        MODE_ESC: begin
          if (ch == CH_NUL) begin
            finish_line(1'b0, CH_NUL, ch);
          end else begin
            emit(ch);
            had_quote = 1'b1;
            scan      = MODE_WORD;
          end
        end
        MODE_DQ_ESC: begin
          scan = MODE_DQUOTE;
          if (ch == CH_BSLASH || ch == CH_DQUOTE || ch == CH_DOLLAR || ch == CH_BTICK) begin
            emit(ch);
          end else begin
            emit(CH_BSLASH);
            handle(ch);
          end
        end
        MODE_TILDE: begin
          // held tilde: expands unless followed by end, slash or blank
          if (ch != CH_NUL && ch != CH_SLASH && !is_blank(ch)) begin
            if (open_word) begin
              close_word();
            end
            finish_line(1'b1, CH_TILDE, ch);
          end else if (!open_word && words_seen >= word_limit) begin
            finish_line(1'b0, CH_NUL, ch);
          end else begin
            if (!open_word) begin
              open_word = 1'b1;
              had_quote = 1'b0;
            end
            scan = MODE_WORD;
            emit(CH_TILDE);
            bump();
            handle(ch);
          end
        end
        default: handle(ch);
      endcase
      if (!restarted && scan != MODE_TILDE) begin
        bump();
      end
      foreach (step_res[i]) begin
        r      = step_res[i];
        r.last = (i == step_res.size() - 1);
        case (r.kind)
          KIND_END: n_ends++;
          KIND_OK:  n_ok++;
          KIND_ERR: n_err++;
          default:  ;
        endcase
        expected_q.push_back(r);
      end
    endfunction

    // Compares one result transfer with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      bit      bad;
      n_results++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("ERROR: unexpected result kind=%0d byte=%02h q=%0d cons=%0d last=%0d",
                   got.kind, got.out_byte, got.word_quoted, got.consumed, got.last);
        end
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      bad = (got.kind != exp_r.kind) || (got.out_byte != exp_r.out_byte) ||
            (got.word_quoted != exp_r.word_quoted) ||
            (got.consumed != exp_r.consumed) || (got.last != exp_r.last);
      if (bad) begin
        if (mismatches < 10) begin
          $display("ERROR: result %0d exp kind=%0d byte=%02h q=%0d cons=%0d last=%0d",
                   n_results, exp_r.kind, exp_r.out_byte, exp_r.word_quoted,
                   exp_r.consumed, exp_r.last);
          $display("       got kind=%0d byte=%02h q=%0d cons=%0d last=%0d",
                   got.kind, got.out_byte, got.word_quoted, got.consumed, got.last);
        end
        mismatches++;
      end
    endfunction

    // Results still owed at the end count as failures
    function void settle();
      if (expected_q.size() != 0) begin
        $display("ERROR: %0d expected results never arrived", expected_q.size());
        mismatches += expected_q.size();
        expected_q.delete();
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Shell word splitter testbench
// Feeds directed and random command lines through the byte channel, with
// random gaps and result back-pressure, under several max_words settings,
// and checks every result transfer against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import swsp_pkg::*;
  import swsp_tb_pkg::*;

  localparam logic [APB_ADDR_W-1:0] MAX_WORDS_ADDR = {REG_MAX_WORDS, 2'b00};
  localparam int                    PHASE_BYTES    = 28;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bit                    calm;        // no idling on either side
  logic [7:0]            line_q[$];
  split_scoreboard       sb;

  swsp_in_if  byte_if ();
  swsp_out_if res_if ();

  shell_word_splitter #(.POSITION_BITS(16)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Result side: check each transfer, random back-pressure
  initial begin
    result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.kind        = kind_e'(res_if.kind);
        got.out_byte    = res_if.out_byte;
        got.word_quoted = res_if.word_quoted;
        got.consumed    = res_if.consumed;
        got.last        = res_if.last;
        sb.check_result(got);
      end
      res_if.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // ---- line generation ----

  function automatic logic [7:0] any_nz();
    return 8'($urandom_range(1, 255));
  endfunction

  // A byte with no special meaning outside quotes
  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do begin
      ch = any_nz();
    end while (is_blank(ch) || is_stop(ch) || ch == CH_SQUOTE || ch == CH_DQUOTE ||
               ch == CH_BSLASH || ch == CH_TILDE);
    return ch;
  endfunction

  function automatic logic [7:0] stop_char();
    logic [7:0] ch;
    do begin
      ch = any_nz();
    end while (!is_stop(ch));
    return ch;
  endfunction

  function automatic void add_gap();
    repeat ($urandom_range(1, 2)) begin
      line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
  endfunction

  function automatic void add_junk();
    repeat ($urandom_range(0, 3)) begin
      line_q.push_back(any_nz());
    end
  endfunction

  // One word made of plain runs, quoted parts, escapes and tildes
  function automatic void add_word();
    logic [7:0] ch;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 3)) line_q.push_back(plain_char());
        end
        4, 5: begin
          line_q.push_back(CH_SQUOTE);
          repeat ($urandom_range(0, 3)) begin
            do begin
              ch = any_nz();
            end while (ch == CH_SQUOTE);
            line_q.push_back(ch);
          end
          line_q.push_back(CH_SQUOTE);
        end
        6, 7: begin
          line_q.push_back(CH_DQUOTE);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) begin
              line_q.push_back(CH_BSLASH);
              case ($urandom_range(0, 4))
                0:       line_q.push_back(CH_BSLASH);
                1:       line_q.push_back(CH_DQUOTE);
                2:       line_q.push_back(CH_DOLLAR);
                3:       line_q.push_back(CH_BTICK);
                default: line_q.push_back(plain_char());
              endcase
            end else begin
              do begin
                ch = any_nz();
              end while (ch == CH_DQUOTE || ch == CH_BSLASH || ch == CH_DOLLAR ||
                         ch == CH_BTICK);
              line_q.push_back(ch);
            end
          end
          line_q.push_back(CH_DQUOTE);
        end
        8: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(any_nz());
        end
        default: begin
          line_q.push_back(CH_TILDE);
          if ($urandom_range(0, 1)) line_q.push_back(CH_SLASH);
        end
      endcase
    end
  endfunction

  // Mostly well-formed lines, some noise and broken endings
  function automatic void build_line();
    int words;
    line_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_NUL);
      return;
    end
    if ($urandom_range(0, 3) == 0) add_gap();
    words = $urandom_range(0, 4);
    for (int w = 0; w < words; w++) begin
      if (w > 0) add_gap();
      add_word();
    end
    if (words > 0 && $urandom_range(0, 2) == 0) add_gap();
    case ($urandom_range(0, 19))
      11, 12, 13, 14: begin
        line_q.push_back(stop_char());
        add_junk();
      end
      15, 16: begin
        if (words > 0) add_gap();
        line_q.push_back(CH_TILDE);
        line_q.push_back(plain_char());
        add_junk();
      end
      17: begin
        line_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
        line_q.push_back(plain_char());
      end
      18: line_q.push_back(CH_BSLASH);
      19: begin
        line_q.push_back(CH_DQUOTE);
        line_q.push_back(plain_char());
        line_q.push_back($urandom_range(0, 1) ? CH_DOLLAR : CH_BTICK);
        add_junk();
      end
      default: ;
    endcase
    line_q.push_back(CH_NUL);
  endfunction

  // ---- drivers ----

  // Each cycle idles with a chance of 19 in a hundred before the transfer
  task automatic send_byte(input logic [7:0] ch);
    while (!calm && $urandom_range(0, 99) < 19) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= ch;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sb.note_byte(ch);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  // Stop sending until every expected result is in, then let the pipe settle
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_words(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_WORDS_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_max_words(v);
  endtask

  // ---- main sequence ----
  initial begin
    logic [7:0] limits[4];
    int         sent;
    bit         paused;
    sb = new();
    calm            = 1'b0;
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.in_byte <= CH_NUL;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at the reset word limit: quoting, escapes, drain after a
    // stop, tilde kept and tilde stop, backtick in quotes, trailing backslash
    line_q = '{"a", CH_TAB, 8'hFF, CH_SQUOTE, CH_SPACE, CH_SQUOTE, CH_DQUOTE,
               CH_BSLASH, CH_DOLLAR, CH_BSLASH, "q", CH_DQUOTE, CH_SEMI, "z", CH_NUL,
               CH_TILDE, CH_SLASH, CH_SPACE, CH_TILDE, "x", CH_NUL,
               CH_DQUOTE, CH_BTICK, CH_NUL, CH_BSLASH, CH_NUL};
    send_line();
    wait_drained();

    // Random phases over several word limits
    limits = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254))};
    paused = 1'b0;
    foreach (limits[p]) begin
      write_max_words(limits[p]);
      calm = (p == 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_line();
        send_line();
        sent += line_q.size();
        if (p == 2 && !paused && sent >= PHASE_BYTES / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk_i);
    sb.settle();
    $display("Sent %0d bytes, checked %0d results: %0d word ends, %0d clean stops, %0d errors",
             sb.n_bytes, sb.n_results, sb.n_ends, sb.n_ok, sb.n_err);
    $display("Word limits 64, 1, 255, 2 and %0d; one phase with no idling, %0d mismatches",
             limits[3], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== shell_word_splitter.f =====
design/swsp_pkg.sv
design/swsp_in_if.sv
design/swsp_out_if.sv
design/swsp_step.sv
design/swsp_rbuf.sv
design/shell_word_splitter.sv
tb/sv/swsp_tb_pkg.sv
tb/sv/tb_top.sv
